// ----- rtl/pfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsm_pkg
// Shared types, codes and defaults of the programmable transition table FSM.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsm_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_ACTIONS_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;

  // Fixed port field widths
  localparam int CMD_W     = 3;
  localparam int FIELD_W   = 16;
  localparam int ACT_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_STATES_IN_USE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIONS_IN_USE = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     STATES_RESET       = CFG_W'(16);
  localparam logic [CFG_W-1:0]     ACTIONS_RESET      = CFG_W'(16);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 3'd0,
    CMD_ADD_STATE  = 3'd1,
    CMD_ADD_TRANS  = 3'd2,
    CMD_BULK       = 3'd3,
    CMD_BULK_REPL  = 3'd4,
    CMD_TAKE       = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_BAD     = 2'd1,
    STS_FULL    = 2'd2,
    STS_NOTRANS = 2'd3
  } sts_t;

  // Slot pointer update
  typedef enum logic [2:0] {
    PTR_HOLD      = 3'd0,
    PTR_ZERO      = 3'd1,
    PTR_INC       = 3'd2,
    PTR_OUTER_INC = 3'd3,
    PTR_LOAD_B    = 3'd4
  } ptr_op_t;

  // Search key update
  typedef enum logic [1:0] {
    KEY_HOLD = 2'd0,
    KEY_SID  = 2'd1,
    KEY_TID  = 2'd2,
    KEY_CALC = 2'd3
  } key_op_t;

  // Transition table address source
  typedef enum logic [1:0] {
    TBL_SWEEP  = 2'd0,
    TBL_SLOT_A = 2'd1,
    TBL_PTR    = 2'd2,
    TBL_OUTER  = 2'd3
  } tbl_sel_t;

  // Transition table write data source
  typedef enum logic [1:0] {
    WD_NONE   = 2'd0,
    WD_PTR    = 2'd1,
    WD_SLOT_B = 2'd2
  } tbl_wd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     latch;
    ptr_op_t  ptr_op;
    key_op_t  key_op;
    logic     cap_a;
    logic     cap_b;
    logic     save_outer;
    logic     id_we;
    logic     tbl_we;
    tbl_sel_t tbl_sel;
    tbl_wd_t  tbl_wd;
    logic     sweep_inc;
    logic     res_load;
    sts_t     res_status;
    logic     res_slot_ptr;
    logic     res_next_id;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t op;
    logic sid_zero;
    logic act_ok;
    logic ptr_end;
    logic id_empty;
    logic key_hit;
    logic mask_hit;
    logic b_out;
    logic sweep_last;
    logic sweep_ids;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pfsm_ram.sv -----
// ----------------------------------------------------------------------------
// pfsm_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsm_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/pfsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfsm_ctrl
// Command sequencer: clearing sweep, slot scans, bulk loops and table reads.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsm_ctrl import pfsm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd,
  output logic           busy
);

  typedef enum logic [12:0] {
    S_INIT    = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_DECODE  = 13'b0000000000100,
    S_CLEAR   = 13'b0000000001000,
    S_ALLOC   = 13'b0000000010000,
    S_FIND_A  = 13'b0000000100000,
    S_FIND_B  = 13'b0000001000000,
    S_BULK    = 13'b0000010000000,
    S_OUTER   = 13'b0000100000000,
    S_INNER   = 13'b0001000000000,
    S_TBL_RD  = 13'b0010000000000,
    S_TBL_CHK = 13'b0100000000000,
    S_ID_RD   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        cmd.id_we     = sts.sweep_ids;
        cmd.tbl_we    = 1'b1;
        cmd.tbl_sel   = TBL_SWEEP;
        cmd.tbl_wd    = WD_NONE;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
          if (state_r == S_CLEAR) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STS_OK;
          end
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd.ptr_op = PTR_ZERO;
        state_nxt  = S_IDLE;
        unique case (sts.op)
          CMD_CLEAR: state_nxt = S_CLEAR;
          CMD_ADD_STATE: begin
            if (sts.sid_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STS_BAD;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
          CMD_ADD_TRANS, CMD_TAKE: begin
            if (!sts.act_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STS_BAD;
            end else begin
              cmd.key_op = KEY_SID;
              state_nxt  = S_FIND_A;
            end
          end
          CMD_BULK: begin
            if (!sts.act_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STS_BAD;
            end else begin
              cmd.key_op = KEY_TID;
              state_nxt  = S_FIND_B;
            end
          end
          CMD_BULK_REPL: begin
            if (!sts.act_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STS_BAD;
            end else begin
              state_nxt = S_OUTER;
            end
          end
          CMD_FIND: begin
            cmd.key_op = KEY_SID;
            state_nxt  = S_FIND_A;
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STS_BAD;
          end
        endcase
      end

      // First free slot
      S_ALLOC: begin
        priority if (sts.ptr_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_FULL;
          state_nxt      = S_IDLE;
        end else if (sts.id_empty) begin
          cmd.id_we        = 1'b1;
          cmd.res_load     = 1'b1;
          cmd.res_status   = STS_OK;
          cmd.res_slot_ptr = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      // Source state lookup
      S_FIND_A: begin
        priority if (sts.ptr_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_BAD;
          state_nxt      = S_IDLE;
        end else if (sts.key_hit) begin
          cmd.cap_a = 1'b1;
          priority if (sts.op == CMD_FIND) begin
            cmd.res_load     = 1'b1;
            cmd.res_status   = STS_OK;
            cmd.res_slot_ptr = 1'b1;
            state_nxt        = S_IDLE;
          end else if (sts.op == CMD_ADD_TRANS) begin
            cmd.key_op = KEY_TID;
            cmd.ptr_op = PTR_ZERO;
            state_nxt  = S_FIND_B;
          end else begin
            state_nxt = S_TBL_RD;
          end
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      // Target state lookup
      S_FIND_B: begin
        priority if (sts.ptr_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_BAD;
          state_nxt      = S_IDLE;
        end else if (sts.key_hit) begin
          if (sts.op == CMD_ADD_TRANS) begin
            cmd.tbl_we     = 1'b1;
            cmd.tbl_sel    = TBL_SLOT_A;
            cmd.tbl_wd     = WD_PTR;
            cmd.res_load   = 1'b1;
            cmd.res_status = STS_OK;
            state_nxt      = S_IDLE;
          end else begin
            cmd.cap_b  = 1'b1;
            cmd.ptr_op = PTR_ZERO;
            state_nxt  = S_BULK;
          end
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      // Fixed-target bulk add over every slot in use whose id matches the mask
      S_BULK: begin
        if (sts.ptr_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_OK;
          state_nxt      = S_IDLE;
        end else begin
          cmd.tbl_we  = sts.mask_hit;
          cmd.tbl_sel = TBL_PTR;
          cmd.tbl_wd  = WD_SLOT_B;
          cmd.ptr_op  = PTR_INC;
        end
      end

      // Replace mode: outer loop over source slots
      S_OUTER: begin
        priority if (sts.ptr_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_OK;
          state_nxt      = S_IDLE;
        end else if (sts.mask_hit) begin
          cmd.save_outer = 1'b1;
          cmd.key_op     = KEY_CALC;
          cmd.ptr_op     = PTR_ZERO;
          state_nxt      = S_INNER;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      // Replace mode: look up the computed target
      S_INNER: begin
        priority if (sts.ptr_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_BAD;
          state_nxt      = S_IDLE;
        end else if (sts.key_hit) begin
          cmd.tbl_we  = 1'b1;
          cmd.tbl_sel = TBL_OUTER;
          cmd.tbl_wd  = WD_PTR;
          cmd.ptr_op  = PTR_OUTER_INC;
          state_nxt   = S_OUTER;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end

      S_TBL_RD: begin
        cmd.tbl_sel = TBL_SLOT_A;
        state_nxt   = S_TBL_CHK;
      end

      S_TBL_CHK: begin
        if (sts.b_out) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STS_NOTRANS;
          state_nxt      = S_IDLE;
        end else begin
          cmd.ptr_op = PTR_LOAD_B;
          state_nxt  = S_ID_RD;
        end
      end

      S_ID_RD: begin
        cmd.res_load    = 1'b1;
        cmd.res_status  = STS_OK;
        cmd.res_next_id = 1'b1;
        state_nxt       = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pfsm_dpath.sv -----
// ----------------------------------------------------------------------------
// pfsm_dpath
// Operand registers, id store, transition table, scan pointer and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfsm_dpath import pfsm_pkg::*; #(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [FIELD_W-1:0]  in_state_id,
  input  wire logic [FIELD_W-1:0]  in_target_id,
  input  wire logic [ACT_W-1:0]    in_action,
  input  wire logic [FIELD_W-1:0]  in_mask,
  input  wire logic [FIELD_W-1:0]  in_replace_bits,
  input  wire logic [CFG_W-1:0]    states_in_use,
  input  wire logic [CFG_W-1:0]    actions_in_use,
  input  wire ctrl_cmd_t           cmd,
  output ctrl_sts_t                sts,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [FIELD_W-1:0]       out_next_state_id,
  output logic [SLOT_W-1:0]        out_slot
);

  localparam int IW  = ID_WIDTH;
  localparam int SIW = $clog2(MAX_STATES);
  localparam int SW  = $clog2(MAX_STATES + 1);
  localparam int ABW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int TAW = SIW + ABW;
  localparam int TD  = MAX_STATES * (2 ** ABW);

  // Operands of the current command
  cmd_t            op_r;
  logic [IW-1:0]   sid_r, tid_r, msk_r, rep_r;
  logic [ACT_W-1:0] act_r;

  // Scan state
  logic [IW-1:0]   key_r, key_nxt;
  logic [SW-1:0]   ptr_r, ptr_nxt;
  logic [SW-1:0]   outer_r, slot_a_r, slot_b_r;
  logic [TAW-1:0]  sweep_r;

  // Result registers
  logic            vld_r;
  sts_t            sts_r;
  logic [IW-1:0]   next_r;
  logic [SW-1:0]   slot_r;

  // Memories
  logic [SIW-1:0]  id_addr;
  logic [IW-1:0]   id_wdata, id_rd;
  logic [TAW-1:0]  tbl_addr;
  logic [SW-1:0]   tbl_wdata, tbl_rd;

  // Widening helpers
  logic [31:0]     sid_w, tid_w, msk_w, rep_w;
  logic [31:0]     ns_w, na_w, act_w, next_w, slot_w;
  logic [SW-1:0]   ns;
  logic [ABW-1:0]  act_idx;

  assign sid_w = 32'(in_state_id);
  assign tid_w = 32'(in_target_id);
  assign msk_w = 32'(in_mask);
  assign rep_w = 32'(in_replace_bits);

  // Effective slot and action counts
  assign ns_w = (32'(states_in_use) > MAX_STATES) ? MAX_STATES : 32'(states_in_use);
  assign na_w = (32'(actions_in_use) > MAX_ACTIONS) ? MAX_ACTIONS : 32'(actions_in_use);
  assign ns   = ns_w[SW-1:0];

  assign act_w   = 32'(act_r);
  assign act_idx = act_w[ABW-1:0];

  // Operand capture on a new transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= cmd_t'(in_command);
      sid_r <= sid_w[IW-1:0];
      tid_r <= tid_w[IW-1:0];
      msk_r <= msk_w[IW-1:0];
      rep_r <= rep_w[IW-1:0];
      act_r <= in_action;
    end
  end

  // Slot pointer; the id store is read at its next value so that the read
  // data lines up with the pointer register
  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD:      ptr_nxt = ptr_r;
      PTR_ZERO:      ptr_nxt = '0;
      PTR_INC:       ptr_nxt = ptr_r + SW'(1);
      PTR_OUTER_INC: ptr_nxt = outer_r + SW'(1);
      PTR_LOAD_B:    ptr_nxt = tbl_rd;
      default:       ptr_nxt = ptr_r;
    endcase
  end

  // Search key
  always_comb begin
    unique case (cmd.key_op)
      KEY_HOLD: key_nxt = key_r;
      KEY_SID:  key_nxt = sid_r;
      KEY_TID:  key_nxt = tid_r;
      KEY_CALC: key_nxt = (id_rd & ~rep_r) | tid_r;
      default:  key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    if (cmd.cap_a) begin
      slot_a_r <= ptr_r;
    end
    if (cmd.cap_b) begin
      slot_b_r <= ptr_r;
    end
    if (cmd.save_outer) begin
      outer_r <= ptr_r;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_inc) begin
      sweep_r <= sts.sweep_last ? '0 : sweep_r + TAW'(1);
    end
  end

  // Id store
  assign id_addr  = cmd.sweep_inc ? sweep_r[SIW-1:0] : ptr_nxt[SIW-1:0];
  assign id_wdata = cmd.sweep_inc ? '0 : sid_r;

  pfsm_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_STATES)
  ) u_id_ram (
    .clk   (clk),
    .we    (cmd.id_we),
    .addr  (id_addr),
    .wdata (id_wdata),
    .rdata (id_rd)
  );

  // Transition table, row per source slot, column per action
  always_comb begin
    unique case (cmd.tbl_sel)
      TBL_SWEEP:  tbl_addr = sweep_r;
      TBL_SLOT_A: tbl_addr = {slot_a_r[SIW-1:0], act_idx};
      TBL_PTR:    tbl_addr = {ptr_r[SIW-1:0], act_idx};
      TBL_OUTER:  tbl_addr = {outer_r[SIW-1:0], act_idx};
      default:    tbl_addr = sweep_r;
    endcase
  end

  always_comb begin
    unique case (cmd.tbl_wd)
      WD_NONE:   tbl_wdata = SW'(MAX_STATES);
      WD_PTR:    tbl_wdata = ptr_r;
      WD_SLOT_B: tbl_wdata = slot_b_r;
      default:   tbl_wdata = SW'(MAX_STATES);
    endcase
  end

  pfsm_ram #(
    .WIDTH (SW),
    .DEPTH (TD)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (cmd.tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rd)
  );

  // Status to the controller; id zero never matches
  always_comb begin
    sts.op         = op_r;
    sts.sid_zero   = (sid_r == '0);
    sts.act_ok     = (act_w < na_w);
    sts.ptr_end    = (ptr_r >= ns);
    sts.id_empty   = (id_rd == '0);
    sts.key_hit    = (key_r != '0) && (id_rd == key_r);
    sts.mask_hit   = (id_rd != '0) && ((id_rd & msk_r) == msk_r);
    sts.b_out      = (tbl_rd >= ns);
    sts.sweep_last = (sweep_r == TAW'(TD - 1));
    sts.sweep_ids  = (32'(sweep_r) < MAX_STATES);
  end

  // Result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      sts_r  <= cmd.res_status;
      slot_r <= cmd.res_slot_ptr ? ptr_r : SW'(MAX_STATES);
      next_r <= cmd.res_next_id ? id_rd : '0;
    end
  end

  assign next_w            = 32'(next_r);
  assign slot_w            = 32'(slot_r);
  assign out_valid         = vld_r;
  assign out_status        = sts_r;
  assign out_next_state_id = next_w[FIELD_W-1:0];
  assign out_slot          = slot_w[SLOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/programmable_fsm_transition_table.sv -----
// ----------------------------------------------------------------------------
// programmable_fsm_transition_table
// Scans step through the ns = states in use slots, one slot per cycle, set by
// the id store read port. Clear sweeps all MAX_STATES * 2**clog2(MAX_ACTIONS)
// table entries, one table entry per cycle. One command at a time; one-cycle
// result strobe, no stall. Reset runs the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module programmable_fsm_transition_table import pfsm_pkg::*; #(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [FIELD_W-1:0]   in_state_id,
  input  wire logic [FIELD_W-1:0]   in_target_id,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [FIELD_W-1:0]   in_mask,
  input  wire logic [FIELD_W-1:0]   in_replace_bits,
  // result channel
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic [FIELD_W-1:0]        out_next_state_id,
  output logic [SLOT_W-1:0]         out_slot,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] states_r, actions_r;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_r  <= STATES_RESET;
      actions_r <= ACTIONS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STATES_IN_USE:  states_r  <= cfg_data;
        REG_ACTIONS_IN_USE: actions_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pfsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  pfsm_dpath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_ACTIONS (MAX_ACTIONS),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_command),
    .in_state_id       (in_state_id),
    .in_target_id      (in_target_id),
    .in_action         (in_action),
    .in_mask           (in_mask),
    .in_replace_bits   (in_replace_bits),
    .states_in_use     (states_r),
    .actions_in_use    (actions_r),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_next_state_id (out_next_state_id),
    .out_slot          (out_slot)
  );

  // The result strobe comes as the sequencer returns to idle
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while busy");

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // An accepted transaction never completes in the following cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction not held busy");

  // Only a successful result carries a next state id
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STS_OK)) |-> (out_next_state_id == '0))
    else $error("next state id on a failed result");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the programmable transition table FSM. A short
// directed table walks the special cases (id zero, duplicates, full store,
// action and table range, bulk replace stopping early, register changes),
// then constrained-by-hand random phases build state families, wire them up
// and query them under several register settings. Typed rows carry their own
// result; others are checked against an in-bench id store and table model.
// ----------------------------------------------------------------------------

module testbench;
  import pfsm_pkg::*;

  localparam int SLOTS   = MAX_STATES_DEF;
  localparam int ACTIONS = MAX_ACTIONS_DEF;

  localparam logic [CMD_W-1:0]     CMD_UNUSED   = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;

  // Expected outcome of one command
  typedef struct packed {
    sts_t        status;
    logic [15:0] next_id;
    logic [4:0]  slot;
  } fsm_result_t;

  // Directed table: config rows carry the register index in act and the value in slot
  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  op;
    logic [15:0] sid;
    logic [15:0] tid;
    logic [3:0]  act;
    logic [15:0] msk;
    logic [15:0] rep;
    sts_t        sts;
    logic [15:0] nxt;
    logic [4:0]  slot;
  } stim_row_t;

  // Clock, reset and block inputs
  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 start           = 1'b0;
  logic [CMD_W-1:0]     in_command      = '0;
  logic [FIELD_W-1:0]   in_state_id     = '0;
  logic [FIELD_W-1:0]   in_target_id    = '0;
  logic [ACT_W-1:0]     in_action       = '0;
  logic [FIELD_W-1:0]   in_mask         = '0;
  logic [FIELD_W-1:0]   in_replace_bits = '0;
  logic                 cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [CFG_W-1:0]     cfg_data        = '0;

  logic                 busy;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [FIELD_W-1:0]   out_next_state_id;
  logic [SLOT_W-1:0]    out_slot;
  logic                 cfg_ready;

  // Model of the block: registers, id store and transition table
  logic [4:0]  states_reg;
  logic [4:0]  actions_reg;
  logic [15:0] model_ids [SLOTS];
  logic [4:0]  trans_tbl [SLOTS][ACTIONS];

  fsm_result_t awaited_outcomes [$];
  int          sent_count  = 0;
  int          fault_count = 0;
  int          idle_pct    = 26;

  int phase_states  [9] = '{16, 1, 2, 16, 0, 31, 5, 16, 3};
  int phase_actions [9] = '{16, 1, 16, 2, 0, 31, 7, 16, 3};
  int phase_items   [9] = '{200, 150, 150, 200, 60, 200, 180, 200, 160};
  int phase_idle    [9] = '{26, 26, 26, 26, 26, 26, 26, 0, 26};

  stim_row_t directed_rows [27] = '{
    // id zero never matches and cannot be added; empty store knows nothing
    '{ROW_TYPED, CMD_FIND, 16'h0000, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_BAD, 16'h0000, 5'd16},
    '{ROW_TYPED, CMD_ADD_STATE, 16'h0000, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_BAD, 16'h0000, 5'd16},
    '{ROW_TYPED, CMD_TAKE, 16'hFFFF, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_BAD, 16'h0000, 5'd16},
    // first free slot, duplicates accepted, lowest slot wins
    '{ROW_TYPED, CMD_ADD_STATE, 16'hFFFF, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd0},
    '{ROW_TYPED, CMD_ADD_STATE, 16'h0001, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd1},
    '{ROW_TYPED, CMD_ADD_STATE, 16'h0001, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd2},
    '{ROW_TYPED, CMD_FIND, 16'h0001, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd1},
    // single transition on the top action
    '{ROW_TYPED, CMD_TAKE, 16'hFFFF, 16'h0000, 4'd15, 16'h0000, 16'h0000,
      STS_NOTRANS, 16'h0000, 5'd16},
    '{ROW_PRED, CMD_ADD_TRANS, 16'hFFFF, 16'h0001, 4'd15, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd0},
    '{ROW_TYPED, CMD_TAKE, 16'hFFFF, 16'h0000, 4'd15, 16'h0000, 16'h0000,
      STS_OK, 16'h0001, 5'd16},
    '{ROW_TYPED, CMD_ADD_TRANS, 16'hFFFF, 16'h1234, 4'd0, 16'h0000, 16'h0000,
      STS_BAD, 16'h0000, 5'd16},
    // bulk add: unknown target, then a masked sweep
    '{ROW_TYPED, CMD_BULK, 16'h0000, 16'h5555, 4'd0, 16'h0001, 16'h0000,
      STS_BAD, 16'h0000, 5'd16},
    '{ROW_PRED, CMD_BULK, 16'h0000, 16'hFFFF, 4'd0, 16'h0001, 16'h0000,
      STS_OK, 16'h0000, 5'd0},
    '{ROW_PRED, CMD_TAKE, 16'h0001, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd0},
    // bulk replace stops at the first unknown target
    '{ROW_TYPED, CMD_BULK_REPL, 16'h0000, 16'h0000, 4'd1, 16'hFFFF, 16'h00F0,
      STS_BAD, 16'h0000, 5'd16},
    '{ROW_PRED, CMD_ADD_STATE, 16'h8000, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd0},
    '{ROW_PRED, CMD_BULK_REPL, 16'h0000, 16'h8000, 4'd1, 16'h0000, 16'hFFFF,
      STS_OK, 16'h0000, 5'd0},
    '{ROW_PRED, CMD_TAKE, 16'h0001, 16'h0000, 4'd1, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd0},
    '{ROW_TYPED, CMD_UNUSED, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF,
      STS_BAD, 16'h0000, 5'd16},
    // shrink both registers: store and table survive
    '{ROW_CFG, CMD_CLEAR, 16'h0000, 16'h0000, REG_STATES_IN_USE, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd2},
    '{ROW_CFG, CMD_CLEAR, 16'h0000, 16'h0000, REG_ACTIONS_IN_USE, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd2},
    '{ROW_TYPED, CMD_TAKE, 16'hFFFF, 16'h0000, 4'd2, 16'h0000, 16'h0000,
      STS_BAD, 16'h0000, 5'd16},
    // entry points at slot 3, beyond the two slots now in use
    '{ROW_TYPED, CMD_TAKE, 16'hFFFF, 16'h0000, 4'd1, 16'h0000, 16'h0000,
      STS_NOTRANS, 16'h0000, 5'd16},
    '{ROW_TYPED, CMD_ADD_STATE, 16'h0002, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_FULL, 16'h0000, 5'd16},
    '{ROW_CFG, CMD_CLEAR, 16'h0000, 16'h0000, REG_UNMAPPED, 16'h0000, 16'h0000,
      STS_OK, 16'h0000, 5'd3},
    '{ROW_TYPED, CMD_CLEAR, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF,
      STS_OK, 16'h0000, 5'd16},
    '{ROW_TYPED, CMD_FIND, 16'h0001, 16'h0000, 4'd0, 16'h0000, 16'h0000,
      STS_BAD, 16'h0000, 5'd16}
  };

  programmable_fsm_transition_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_state_id      (in_state_id),
    .in_target_id     (in_target_id),
    .in_action        (in_action),
    .in_mask          (in_mask),
    .in_replace_bits  (in_replace_bits),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_next_state_id(out_next_state_id),
    .out_slot         (out_slot),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Model helpers
  function automatic int live_states();
    return (int'(states_reg) > SLOTS) ? SLOTS : int'(states_reg);
  endfunction

  function automatic int live_actions();
    return (int'(actions_reg) > ACTIONS) ? ACTIONS : int'(actions_reg);
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < SLOTS; i++) begin
      model_ids[i] = '0;
      for (int j = 0; j < ACTIONS; j++) trans_tbl[i][j] = 5'(SLOTS);
    end
  endfunction

  // Lowest live slot holding id, SLOTS when absent; id zero never matches
  function automatic int slot_of(input logic [15:0] id);
    int hit;
    hit = SLOTS;
    if (id != '0) begin
      for (int i = live_states() - 1; i >= 0; i--) begin
        if (model_ids[i] == id) hit = i;
      end
    end
    return hit;
  endfunction

  // Executes one command on the model and returns its outcome
  function automatic fsm_result_t table_fsm_outcome(input logic [2:0] op,
      input logic [15:0] sid, input logic [15:0] tid, input logic [3:0] act,
      input logic [15:0] msk, input logic [15:0] rep);
    fsm_result_t res;
    int          ns;
    int          a;
    int          b;
    logic        act_ok;
    logic        done;
    logic [15:0] id;
    res.status  = STS_BAD;
    res.next_id = '0;
    res.slot    = 5'(SLOTS);
    ns          = live_states();
    act_ok      = int'(act) < live_actions();
    done        = 1'b0;
    case (op)
      CMD_CLEAR: begin
        clear_model();
        res.status = STS_OK;
      end
      CMD_ADD_STATE: begin
        if (sid != '0) begin
          res.status = STS_FULL;
          for (int i = 0; i < ns && !done; i++) begin
            if (model_ids[i] == '0) begin
              model_ids[i] = sid;
              res.slot     = 5'(i);
              res.status   = STS_OK;
              done         = 1'b1;
            end
          end
        end
      end
      CMD_ADD_TRANS: begin
        a = slot_of(sid);
        b = slot_of(tid);
        if (a < SLOTS && b < SLOTS && act_ok) begin
          trans_tbl[a][act] = 5'(b);
          res.status        = STS_OK;
        end
      end
      CMD_BULK: begin
        b = slot_of(tid);
        if (b < SLOTS && act_ok) begin
          for (int i = 0; i < ns; i++) begin
            id = model_ids[i];
            if (id != '0 && (id & msk) == msk) trans_tbl[i][act] = 5'(b);
          end
          res.status = STS_OK;
        end
      end
      CMD_BULK_REPL: begin
        if (act_ok) begin
          res.status = STS_OK;
          for (int i = 0; i < ns && !done; i++) begin
            id = model_ids[i];
            if (id != '0 && (id & msk) == msk) begin
              b = slot_of((id & ~rep) | tid);
              if (b >= SLOTS) begin
                res.status = STS_BAD;
                done       = 1'b1;
              end else begin
                trans_tbl[i][act] = 5'(b);
              end
            end
          end
        end
      end
      CMD_TAKE: begin
        a = slot_of(sid);
        if (act_ok && a < SLOTS) begin
          b = int'(trans_tbl[a][act]);
          if (b >= ns) begin
            res.status = STS_NOTRANS;
          end else begin
            res.next_id = model_ids[b];
            res.status  = STS_OK;
          end
        end
      end
      CMD_FIND: begin
        a        = slot_of(sid);
        res.slot = 5'(a);
        if (a < SLOTS) res.status = STS_OK;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random field shapes: ids mostly from a family sharing all but the low bits
  function automatic logic [15:0] family_id(input logic [15:0] base);
    if ($urandom_range(15) == 0) return 16'($urandom);
    return base | 16'($urandom_range(7));
  endfunction

  function automatic logic [3:0] pick_action();
    if (live_actions() > 0 && $urandom_range(7) != 0)
      return 4'($urandom_range(live_actions() - 1));
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [15:0] low_pattern();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($urandom_range(7));
  endfunction

  // One command transaction; outcome queued at the accepting edge
  task automatic send_command(input logic [2:0] op, input logic [15:0] sid,
      input logic [15:0] tid, input logic [3:0] act, input logic [15:0] msk,
      input logic [15:0] rep, input logic typed, input fsm_result_t typed_res);
    fsm_result_t predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= op;
    in_state_id     <= sid;
    in_target_id    <= tid;
    in_action       <= act;
    in_mask         <= msk;
    in_replace_bits <= rep;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = table_fsm_outcome(op, sid, tid, act, msk, rep);
    awaited_outcomes.push_back(typed ? typed_res : predicted);
    sent_count++;
  endtask

  // Hold off the sender until every outstanding result is in
  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  // Register write transaction, only with the block idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    while (busy !== 1'b0) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_STATES_IN_USE) states_reg = val;
    else if (idx == REG_ACTIONS_IN_USE) actions_reg = val;
  endtask

  // Random phase: mostly family build-up and use, some noise
  task automatic run_phase(input int n_items);
    int          stop_at;
    int          pick;
    logic [2:0]  op;
    logic [15:0] base;
    logic [15:0] msk;
    logic [15:0] tid;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        base = 16'($urandom) & 16'hFFF8;
        if ($urandom_range(2) == 0)
          send_command(CMD_CLEAR, 16'($urandom), 16'($urandom), 4'($urandom),
                       16'($urandom), 16'($urandom), 1'b0, '0);
        repeat ($urandom_range(live_states() + 2, 1))
          send_command(CMD_ADD_STATE, family_id(base), 16'($urandom), 4'($urandom),
                       16'($urandom), 16'($urandom), 1'b0, '0);
        repeat ($urandom_range(20, 6)) begin
          pick = $urandom_range(99);
          if (pick < 25)      op = CMD_ADD_TRANS;
          else if (pick < 35) op = CMD_BULK;
          else if (pick < 50) op = CMD_BULK_REPL;
          else if (pick < 80) op = CMD_TAKE;
          else if (pick < 95) op = CMD_FIND;
          else                op = CMD_ADD_STATE;
          if ($urandom_range(3) == 0) msk = 16'h0000;
          else msk = (base & 16'($urandom)) | 16'($urandom_range(7) & $urandom_range(7));
          tid = (op == CMD_BULK_REPL) ? low_pattern() : family_id(base);
          send_command(op, family_id(base), tid, pick_action(), msk, low_pattern(),
                       1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          op = 3'($urandom_range(7));
          if (op == CMD_CLEAR && $urandom_range(9) != 0) op = CMD_FIND;
          send_command(op, 16'($urandom), 16'($urandom), 4'($urandom),
                       16'($urandom), 16'($urandom), 1'b0, '0);
        end
      end
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin : check_results
    fsm_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_outcomes.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: unexpected result status %0d next %h slot %0d",
                   $time, out_status, out_next_state_id, out_slot);
        fault_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_status !== want.status || out_next_state_id !== want.next_id ||
            out_slot !== want.slot) begin
          if (fault_count < 10)
            $display("%0t: mismatch: expected status %0d next %h slot %0d, got %0d %h %0d",
                     $time, want.status, want.next_id, want.slot,
                     out_status, out_next_state_id, out_slot);
          fault_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #25_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    stim_row_t   row;
    fsm_result_t typed_res;
    states_reg  = STATES_RESET;
    actions_reg = ACTIONS_RESET;
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.act, row.slot);
      end else begin
        typed_res.status  = row.sts;
        typed_res.next_id = row.nxt;
        typed_res.slot    = row.slot;
        send_command(row.op, row.sid, row.tid, row.act, row.msk, row.rep,
                     row.kind == ROW_TYPED, typed_res);
      end
    end

    // Random phases over several register settings
    for (int p = 0; p < 9; p++) begin
      idle_pct = phase_idle[p];
      write_register(REG_STATES_IN_USE, 5'(phase_states[p]));
      write_register(REG_ACTIONS_IN_USE, 5'(phase_actions[p]));
      run_phase(phase_items[p]);
    end

    wait_drained();
    cfg_valid <= 1'b0;
    repeat (300) @(posedge clk);
    if (fault_count == 0 && awaited_outcomes.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
